[hw/rtl/fdc_pkg.sv]
// ----------------------------------------------------------------------------
// fdc_pkg: shared definitions for the link frame deframer
// Holds the frame layout constants, the CRC-16 step, the store index
// arithmetic and the types passed between the deframer modules.
// ----------------------------------------------------------------------------
package fdc_pkg;

   localparam int MAX_PAYLOAD = 64;
   localparam int OVERHEAD    = 10;
   localparam int STORE_DEPTH = MAX_PAYLOAD + OVERHEAD;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 7;
   localparam int OFS_W       = 6;

   localparam logic [BYTE_W-1:0] HDR_A      = 8'h7A;
   localparam logic [BYTE_W-1:0] HDR_B      = 8'hA7;
   localparam logic [BYTE_W-1:0] VERSION_OK = 8'h01;
   localparam logic [BYTE_W-1:0] TAIL_A     = 8'h0D;
   localparam logic [BYTE_W-1:0] TAIL_B     = 8'h0A;
   localparam logic [15:0]       CRC_INIT   = 16'hFFFF;
   localparam logic [15:0]       CRC_POLY   = 16'hA001;

   localparam int POS_VER     = 2;
   localparam int POS_CMD     = 3;
   localparam int POS_SEQ     = 4;
   localparam int POS_LEN     = 5;
   localparam int POS_PAYLOAD = 6;

   localparam int RSP_CMD_LSB  = 0;
   localparam int RSP_SEQ_LSB  = RSP_CMD_LSB + BYTE_W;
   localparam int RSP_LEN_LSB  = RSP_SEQ_LSB + BYTE_W;
   localparam int RSP_BYTE_LSB = RSP_LEN_LSB + LEN_W;
   localparam int RSP_OFS_LSB  = RSP_BYTE_LSB + BYTE_W;
   localparam int RSP_FIELDS_W = RSP_OFS_LSB + OFS_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [BYTE_W-1:0] byte_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_HUNT_RD,
      ST_HUNT_EV,
      ST_FRM_RD,
      ST_FRM_EV,
      ST_EMIT_RD,
      ST_EMIT_WR
   } fdc_state_type;

   typedef struct packed {
      byte_type         frame_command;
      byte_type         frame_sequence;
      len_type          payload_len;
      byte_type         payload_byte;
      logic             byte_present;
      logic [OFS_W-1:0] byte_offset;
      logic             last_of_frame;
   } fdc_result_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input byte_type data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic idx_type wrap_add(input idx_type base, input cnt_type off);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (s >= (CNT_W+1)'(STORE_DEPTH)) begin
         s = s - (CNT_W+1)'(STORE_DEPTH);
      end
      return IDX_W'(s);
   endfunction

endpackage

[hw/rtl/fdc_ram.sv]
// ----------------------------------------------------------------------------
// fdc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; the read data holds while no
// read is enabled.
// ----------------------------------------------------------------------------
module fdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 74
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/fdc_engine.sv]
// ----------------------------------------------------------------------------
// fdc_engine: frame store sequencer
// Keeps the frame store as a circular buffer in RAM, appends received bytes,
// hunts for the header, sweeps the frame for the CRC and tail check, and
// reads out the payload of a passing frame one result at a time.
// ----------------------------------------------------------------------------
module fdc_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  fdc_pkg::byte_type       in_byte,
   input  logic                    slot_free,
   output logic                    res_load,
   output fdc_pkg::fdc_result_type res,
   output logic                    ram_wr_en,
   output fdc_pkg::idx_type        ram_wr_addr,
   output fdc_pkg::byte_type       ram_wr_data,
   output logic                    ram_rd_en,
   output fdc_pkg::idx_type        ram_rd_addr,
   input  fdc_pkg::byte_type       ram_rd_data
);
   import fdc_pkg::*;

   fdc_state_type state_ff, state_in;
   idx_type       head_ff, head_in;
   cnt_type       fill_ff, fill_in;
   idx_type       i_ff, i_in;
   byte_type      prev_ff, prev_in;
   byte_type      ver_ff, ver_in;
   byte_type      cmd_ff, cmd_in;
   byte_type      seq_ff, seq_in;
   len_type       len_ff, len_in;
   logic [15:0]   crc_ff, crc_in;
   logic [15:0]   rxcrc_ff, rxcrc_in;
   byte_type      tail_a_ff, tail_a_in;
   len_type       k_ff, k_in;

   cnt_type       fill_eff;
   logic          hunt_found;
   cnt_type       hunt_start;
   cnt_type       hunt_fill;
   cnt_type       flen;
   idx_type       crc_end;
   logic          len_bad;
   logic          too_short;
   logic          frame_pass;
   logic          emit_last;

   assign fill_eff   = (fill_ff >= CNT_W'(STORE_DEPTH)) ? '0 : fill_ff;
   assign hunt_found = (i_ff != '0) && (prev_ff == HDR_A) && (ram_rd_data == HDR_B);
   assign hunt_start = hunt_found ? (CNT_W'(i_ff) - CNT_W'(1)) : CNT_W'(i_ff);
   assign hunt_fill  = fill_ff - hunt_start;
   assign flen       = CNT_W'(len_ff) + CNT_W'(OVERHEAD);
   assign crc_end    = IDX_W'(POS_PAYLOAD) + IDX_W'(len_ff);
   assign len_bad    = (ver_ff != VERSION_OK) || (ram_rd_data > BYTE_W'(MAX_PAYLOAD));
   assign too_short  = (9'(fill_ff) < (9'(ram_rd_data) + 9'(OVERHEAD)));
   assign frame_pass = (tail_a_ff == TAIL_A) && (ram_rd_data == TAIL_B) && (rxcrc_ff == crc_ff);
   assign emit_last  = (len_ff == '0) || (LEN_W'(k_ff + LEN_W'(1)) == len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         fill_ff  <= '0;
         crc_ff   <= CRC_INIT;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         crc_ff   <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      prev_ff   <= prev_in;
      ver_ff    <= ver_in;
      cmd_ff    <= cmd_in;
      seq_ff    <= seq_in;
      len_ff    <= len_in;
      rxcrc_ff  <= rxcrc_in;
      tail_a_ff <= tail_a_in;
      k_ff      <= k_in;
   end

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      i_in        = i_ff;
      prev_in     = prev_ff;
      ver_in      = ver_ff;
      cmd_in      = cmd_ff;
      seq_in      = seq_ff;
      len_in      = len_ff;
      crc_in      = crc_ff;
      rxcrc_in    = rxcrc_ff;
      tail_a_in   = tail_a_ff;
      k_in        = k_ff;
      in_ready    = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wrap_add(head_ff, fill_eff);
      ram_wr_data = in_byte;
      ram_rd_en   = 1'b0;
      ram_rd_addr = wrap_add(head_ff, CNT_W'(i_ff));
      res_load    = 1'b0;
      res.frame_command  = cmd_ff;
      res.frame_sequence = seq_ff;
      res.payload_len    = len_ff;
      res.payload_byte   = (len_ff == '0) ? '0 : ram_rd_data;
      res.byte_present   = (len_ff != '0);
      res.byte_offset    = (len_ff == '0) ? '0 : k_ff[OFS_W-1:0];
      res.last_of_frame  = emit_last;

      case (state_ff)
         ST_IDLE: begin
            in_ready = !reset;
            if (in_valid && !reset) begin
               ram_wr_en = 1'b1;
               fill_in   = fill_eff + CNT_W'(1);
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (fill_ff < CNT_W'(OVERHEAD)) begin
               state_in = ST_IDLE;
            end else begin
               i_in     = '0;
               state_in = ST_HUNT_RD;
            end
         end
         ST_HUNT_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_HUNT_EV;
         end
         ST_HUNT_EV: begin
            if (hunt_found || (CNT_W'(i_ff) == (fill_ff - CNT_W'(1)))) begin
               head_in = wrap_add(head_ff, hunt_start);
               fill_in = hunt_fill;
               i_in    = '0;
               crc_in  = CRC_INIT;
               if (hunt_fill < CNT_W'(OVERHEAD)) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FRM_RD;
               end
            end else begin
               prev_in  = ram_rd_data;
               i_in     = i_ff + IDX_W'(1);
               state_in = ST_HUNT_RD;
            end
         end
         ST_FRM_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_FRM_EV;
         end
         ST_FRM_EV: begin
            i_in     = i_ff + IDX_W'(1);
            state_in = ST_FRM_RD;
            if ((i_ff <= IDX_W'(POS_LEN)) || (i_ff < crc_end)) begin
               crc_in = crc_step(crc_ff, ram_rd_data);
            end
            if (i_ff == IDX_W'(POS_VER)) begin
               ver_in = ram_rd_data;
            end
            if (i_ff == IDX_W'(POS_CMD)) begin
               cmd_in = ram_rd_data;
            end
            if (i_ff == IDX_W'(POS_SEQ)) begin
               seq_in = ram_rd_data;
            end
            if (i_ff == IDX_W'(POS_LEN)) begin
               len_in = ram_rd_data[LEN_W-1:0];
               if (len_bad) begin
                  head_in  = wrap_add(head_ff, CNT_W'(1));
                  fill_in  = fill_ff - CNT_W'(1);
                  state_in = ST_CHECK;
               end else if (too_short) begin
                  state_in = ST_IDLE;
               end
            end
            if (i_ff > IDX_W'(POS_LEN)) begin
               if (i_ff == crc_end) begin
                  rxcrc_in[7:0] = ram_rd_data;
               end
               if (i_ff == (crc_end + IDX_W'(1))) begin
                  rxcrc_in[15:8] = ram_rd_data;
               end
               if (i_ff == (crc_end + IDX_W'(2))) begin
                  tail_a_in = ram_rd_data;
               end
               if (i_ff == (crc_end + IDX_W'(3))) begin
                  if (frame_pass) begin
                     i_in     = IDX_W'(POS_PAYLOAD);
                     k_in     = '0;
                     state_in = ST_EMIT_RD;
                  end else begin
                     head_in  = wrap_add(head_ff, flen);
                     fill_in  = fill_ff - flen;
                     state_in = ST_CHECK;
                  end
               end
            end
         end
         ST_EMIT_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            if (slot_free) begin
               res_load = 1'b1;
               if (emit_last) begin
                  head_in  = wrap_add(head_ff, flen);
                  fill_in  = fill_ff - flen;
                  state_in = ST_CHECK;
               end else begin
                  k_in     = k_ff + LEN_W'(1);
                  i_in     = i_ff + IDX_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[hw/rtl/fdc_out_reg.sv]
// ----------------------------------------------------------------------------
// fdc_out_reg: result output register
// Holds one result transaction for the result channel and packs its fields
// onto the stream ports, so the sequencer can move on while it waits.
// ----------------------------------------------------------------------------
module fdc_out_reg (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             res_load,
   input  fdc_pkg::fdc_result_type          res,
   output logic                             slot_free,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fdc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);
   import fdc_pkg::*;

   logic           valid_ff, valid_in;
   fdc_result_type res_ff;

   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (res_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_FIELDS_W)'(0), res_ff.byte_offset, res_ff.payload_byte,
                        res_ff.payload_len, res_ff.frame_sequence, res_ff.frame_command};
   assign rsp_tuser  = res_ff.byte_present;
   assign rsp_tlast  = res_ff.last_of_frame;

endmodule

[hw/rtl/frame_deframer_crc16_core.sv]
// ----------------------------------------------------------------------------
// frame_deframer_crc16_core: header, length and CRC-16/MODBUS deframer
// Finds frames of the form 7A A7 version command sequence length payload
// crc_lo crc_hi 0D 0A in a received byte stream and emits the payload of
// each passing frame as a run of result transactions.
//
// Channel  Dir  Transaction contents
// req_     in   rx_byte
// rsp_     out  command, sequence, length, payload byte, present, offset, last
//
// A received byte is written into the frame store RAM in ST_IDLE, then the
// fill count is checked in ST_CHECK. While ten or more bytes are held, the
// header hunt and frame sweep read stored bytes one at a time through the
// single registered RAM read port, each in a read and an evaluate state; each
// result is read in ST_EMIT_RD and loaded in ST_EMIT_WR, which a low
// rsp_tready holds while the output register is full. A new byte is accepted
// only once this work is done, while the last result may still wait in the
// output register. Reset clears the control state; the store needs no clearing.
// ----------------------------------------------------------------------------
module frame_deframer_crc16_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] rx_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] frame_command, [15:8] frame_sequence, [22:16] payload length,
   // [30:23] payload_byte, [36:31] byte_offset, [39:37] zero
   output logic [fdc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser,   // [0] byte_present
   output logic                           rsp_tlast    // last_of_frame
);
   import fdc_pkg::*;

   logic           slot_free;
   logic           res_load;
   fdc_result_type res;
   logic           ram_wr_en;
   idx_type        ram_wr_addr;
   byte_type       ram_wr_data;
   logic           ram_rd_en;
   idx_type        ram_rd_addr;
   byte_type       ram_rd_data;

   fdc_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_byte     (req_tdata),
      .slot_free   (slot_free),
      .res_load    (res_load),
      .res         (res),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   fdc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fdc_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .res_load   (res_load),
      .res        (res),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[hw/rtl/fdc_checker.sv]
// ----------------------------------------------------------------------------
// fdc_checker: port-level checks for the deframer
// Watches the stream ports of the top level and flags result transactions
// that break the frame run rules, and input accepted again before the stored byte is processed.
// ----------------------------------------------------------------------------
module fdc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [fdc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser,
   input logic                           rsp_tlast
);
   import fdc_pkg::*;

   logic [LEN_W-1:0] rsp_len;
   logic [OFS_W-1:0] rsp_ofs;

   assign rsp_len = rsp_tdata[RSP_LEN_LSB +: LEN_W];
   assign rsp_ofs = rsp_tdata[RSP_OFS_LSB +: OFS_W];

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                        && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("Stalled result transaction changed.");

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("Input accepted again before the stored byte was processed.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tlast && (rsp_len == '0) && (rsp_ofs == '0)))
      else $error("Empty-frame result is malformed.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> ((LEN_W'(rsp_ofs) < rsp_len)
                                     && (rsp_len <= LEN_W'(MAX_PAYLOAD))))
      else $error("Payload offset outside the frame length.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser && rsp_tlast) |-> (LEN_W'(rsp_ofs) + LEN_W'(1) == rsp_len))
      else $error("Last payload result is not the final byte.");

endmodule

bind frame_deframer_crc16_core fdc_checker u_fdc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking testbench for frame_deframer_crc16_core
// Streams received bytes into the deframer and predicts every result
// transaction with a behavioral deframer of its own. Directed frames cover
// field extremes, empty and full payloads, header hunting, bad version and
// length rescans, and CRC and tail failures. Random traffic that is mostly
// well-formed frames follows under several idle and backpressure patterns.
// ----------------------------------------------------------------------------
module tb;
   import fdc_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 400;
   localparam int HOLD_CYCLES    = 600;
   localparam int PHASE_BYTES    = 40;

   typedef enum int {
      DMG_NONE,
      DMG_CRC,
      DMG_TAIL,
      DMG_VERSION,
      DMG_LENGTH
   } damage_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   byte_type       link_store[STORE_DEPTH];
   int             link_fill = 0;
   fdc_result_type expected_results[$];
   byte_type       frame_bytes[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   int errors = 0;
   int bytes_sent = 0;
   int frames_passed = 0;
   int predicted_results = 0;
   int results_seen = 0;
   int quiet_cycles = 0;

   always #10 clock = ~clock;

   frame_deframer_crc16_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   function automatic logic [15:0] crc16_update(input logic [15:0] c, input byte_type d);
      logic [15:0] r;
      r = c ^ {8'h00, d};
      for (int b = 0; b < 8; b++) begin
         if (r[0]) begin
            r = (r >> 1) ^ 16'hA001;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   function automatic void discard_front(input int n);
      if (n >= link_fill) begin
         link_fill = 0;
      end else begin
         for (int i = 0; i < link_fill - n; i++) begin
            link_store[i] = link_store[i + n];
         end
         link_fill -= n;
      end
   endfunction

   function automatic void deframe_byte(input byte_type b);
      int             start;
      int             len;
      int             flen;
      int             count;
      logic [15:0]    rx_crc;
      logic [15:0]    calc_crc;
      fdc_result_type r;
      if (link_fill >= STORE_DEPTH) begin
         link_fill = 0;
      end
      link_store[link_fill] = b;
      link_fill++;
      while (link_fill >= OVERHEAD) begin
         start = 0;
         while (start + 1 < link_fill &&
                !(link_store[start] == HDR_A && link_store[start + 1] == HDR_B)) begin
            start++;
         end
         if (start > 0) begin
            discard_front(start);
         end
         if (link_fill < OVERHEAD) begin
            break;
         end
         if (link_store[POS_VER] != VERSION_OK || link_store[POS_LEN] > MAX_PAYLOAD) begin
            discard_front(1);
            continue;
         end
         len = link_store[POS_LEN];
         flen = OVERHEAD + len;
         if (link_fill < flen) begin
            break;
         end
         rx_crc = {link_store[POS_PAYLOAD + len + 1], link_store[POS_PAYLOAD + len]};
         calc_crc = CRC_INIT;
         for (int i = 0; i < POS_PAYLOAD + len; i++) begin
            calc_crc = crc16_update(calc_crc, link_store[i]);
         end
         if (link_store[flen - 2] == TAIL_A && link_store[flen - 1] == TAIL_B &&
             rx_crc == calc_crc) begin
            count = (len == 0) ? 1 : len;
            for (int k = 0; k < count; k++) begin
               r.frame_command  = link_store[POS_CMD];
               r.frame_sequence = link_store[POS_SEQ];
               r.payload_len    = len_type'(len);
               r.payload_byte   = (len == 0) ? '0 : link_store[POS_PAYLOAD + k];
               r.byte_present   = (len != 0);
               r.byte_offset    = (len == 0) ? '0 : OFS_W'(k);
               r.last_of_frame  = (k == count - 1);
               expected_results.push_back(r);
               predicted_results++;
            end
            frames_passed++;
         end
         discard_front(flen);
      end
   endfunction

   function automatic void check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      fdc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual data %h user %b last %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            errors++;
         end else begin
            want = expected_results.pop_front();
            check_field("frame_command", want.frame_command,
                        rsp_tdata[RSP_CMD_LSB +: BYTE_W]);
            check_field("frame_sequence", want.frame_sequence,
                        rsp_tdata[RSP_SEQ_LSB +: BYTE_W]);
            check_field("payload_len", want.payload_len, rsp_tdata[RSP_LEN_LSB +: LEN_W]);
            check_field("payload_byte", want.payload_byte, rsp_tdata[RSP_BYTE_LSB +: BYTE_W]);
            check_field("byte_offset", want.byte_offset, rsp_tdata[RSP_OFS_LSB +: OFS_W]);
            check_field("byte_present", want.byte_present, rsp_tuser);
            check_field("last_of_frame", want.last_of_frame, rsp_tlast);
            results_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired after %0d cycles without a transaction",
                     $time, quiet_cycles);
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_byte(input byte_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = b;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      deframe_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic build_frame(input byte_type cmd, input byte_type seq, input int len,
                              input int pay_fill, input damage_type damage);
      logic [15:0] crc;
      int          pos;
      frame_bytes = {};
      frame_bytes.push_back(HDR_A);
      frame_bytes.push_back(HDR_B);
      frame_bytes.push_back(VERSION_OK);
      frame_bytes.push_back(cmd);
      frame_bytes.push_back(seq);
      frame_bytes.push_back(byte_type'(len));
      for (int i = 0; i < len; i++) begin
         frame_bytes.push_back((pay_fill < 0) ? byte_type'($urandom) : byte_type'(pay_fill));
      end
      crc = CRC_INIT;
      foreach (frame_bytes[i]) begin
         crc = crc16_update(crc, frame_bytes[i]);
      end
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
      frame_bytes.push_back(TAIL_A);
      frame_bytes.push_back(TAIL_B);
      case (damage)
         DMG_CRC: begin
            pos = POS_PAYLOAD + len + $urandom_range(1);
            frame_bytes[pos] = frame_bytes[pos] ^ byte_type'(1 << $urandom_range(7));
         end
         DMG_TAIL: begin
            pos = POS_PAYLOAD + len + 2 + $urandom_range(1);
            frame_bytes[pos] = frame_bytes[pos] ^ byte_type'(1 << $urandom_range(7));
         end
         DMG_VERSION: begin
            frame_bytes[POS_VER] = $urandom_range(1) ? byte_type'($urandom_range(2, 255)) : '0;
         end
         DMG_LENGTH: begin
            frame_bytes[POS_LEN] = byte_type'($urandom_range(MAX_PAYLOAD + 1, 255));
         end
         default: begin
         end
      endcase
   endtask

   task automatic send_built_frame();
      foreach (frame_bytes[i]) begin
         send_byte(frame_bytes[i]);
      end
   endtask

   task automatic send_packet(input byte_type cmd, input byte_type seq, input int len,
                              input int pay_fill, input damage_type damage);
      build_frame(cmd, seq, len, pay_fill, damage);
      send_built_frame();
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      @(posedge clock);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      @(negedge clock);
   endtask

   task automatic test_field_extremes();
      send_packet(8'h00, 8'h00, 0, -1, DMG_NONE);
      send_packet(8'hFF, 8'hFF, MAX_PAYLOAD, 8'hFF, DMG_NONE);
      send_packet(8'h00, 8'hFF, 1, 8'h00, DMG_NONE);
      send_packet(8'hFF, 8'h00, 2, -1, DMG_NONE);
      send_packet(8'h5A, 8'hA5, 0, -1, DMG_NONE);
   endtask

   task automatic test_header_hunt();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(HDR_A);
      send_byte(8'h55);
      send_byte(HDR_B);
      send_packet(8'h12, 8'h34, 3, -1, DMG_NONE);
      send_byte(HDR_A);
      send_byte(HDR_A);
      send_packet(8'h21, 8'h43, 2, -1, DMG_NONE);
   endtask

   task automatic test_header_rescan();
      send_byte(HDR_A);
      send_byte(HDR_B);
      send_packet(8'h81, 8'h01, 4, -1, DMG_NONE);
      send_packet(8'h82, 8'h02, 5, -1, DMG_VERSION);
      send_packet(8'h83, 8'h03, 1, -1, DMG_NONE);
      build_frame(8'h84, 8'h04, 6, -1, DMG_NONE);
      frame_bytes[POS_LEN] = byte_type'(MAX_PAYLOAD + 1);
      send_built_frame();
      build_frame(8'h85, 8'h05, 2, -1, DMG_NONE);
      frame_bytes[POS_LEN] = 8'hFF;
      send_built_frame();
      send_packet(8'h86, 8'h06, 2, -1, DMG_NONE);
   endtask

   task automatic test_check_failures();
      send_packet(8'h91, 8'h11, 7, -1, DMG_CRC);
      send_packet(8'h92, 8'h12, 3, -1, DMG_NONE);
      send_packet(8'h93, 8'h13, 0, -1, DMG_TAIL);
      send_packet(8'h94, 8'h14, 2, -1, DMG_NONE);
      send_packet(8'h95, 8'h15, 20, -1, DMG_CRC);
      send_packet(8'h96, 8'h16, 0, -1, DMG_NONE);
   endtask

   task automatic test_backpressure();
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      @(negedge clock);
      for (int i = 0; i < 3; i++) begin
         send_packet(byte_type'($urandom), byte_type'(i), 12, -1, DMG_NONE);
      end
   endtask

   task automatic test_random_traffic(input int n_bytes);
      int stop_at;
      int pick;
      int len;
      int len_pick;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         len_pick = $urandom_range(99);
         if (len_pick < 80) begin
            len = $urandom_range(8);
         end else if (len_pick < 95) begin
            len = $urandom_range(9, 32);
         end else begin
            len = $urandom_range(33, MAX_PAYLOAD);
         end
         if (pick < 70) begin
            send_packet(byte_type'($urandom), byte_type'($urandom), len, -1, DMG_NONE);
         end else if (pick < 85) begin
            send_packet(byte_type'($urandom), byte_type'($urandom), len, -1,
                        damage_type'($urandom_range(DMG_CRC, DMG_LENGTH)));
         end else begin
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(3))
                  0: send_byte(HDR_A);
                  1: send_byte(HDR_B);
                  default: send_byte(byte_type'($urandom));
               endcase
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      set_idling(13, 66);
      test_field_extremes();
      test_header_hunt();
      test_header_rescan();
      test_check_failures();
      test_random_traffic(PHASE_BYTES);
      set_idling(66, 13);
      test_random_traffic(PHASE_BYTES);
      set_idling(0, 0);
      test_backpressure();
      test_random_traffic(PHASE_BYTES);
      req_tvalid = 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("tb: %0d bytes sent, %0d frames passed, %0d of %0d predicted results compared",
               bytes_sent, frames_passed, results_seen, predicted_results);
      $display("tb: %0d mismatches found", errors);
      if (errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
